@@ hdl/scl_pkg.sv @@
// shared types, character codes and command codes for the serial command line parser
`timescale 1ns / 1ps

package scl_pkg;

    localparam int LINE_CAPACITY_DEF = 16;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_P     = 8'h70;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_S     = 8'h73;
    localparam logic [7:0] CHAR_R     = 8'h72;

    localparam logic [2:0] CMD_NONE = 3'd0;
    localparam logic [2:0] CMD_P    = 3'd1;
    localparam logic [2:0] CMD_A    = 3'd2;
    localparam logic [2:0] CMD_S    = 3'd3;
    localparam logic [2:0] CMD_R    = 3'd4;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] rx_byte;
        logic       clear_value;
        logic       clear_received;
    } scl_in_t;

    typedef struct packed {
        logic               line_done;
        logic [2:0]         command;
        logic               echo_valid;
        logic [7:0]         echo_byte;
        logic signed [15:0] value;
        logic               received;
        logic               overflow;
    } scl_out_t;

    function automatic logic [2:0] letter_code(input logic [7:0] c);
        logic [2:0] code;
        unique case (c)
            CHAR_P:  code = CMD_P;
            CHAR_A:  code = CMD_A;
            CHAR_S:  code = CMD_S;
            CHAR_R:  code = CMD_R;
            default: code = CMD_NONE;
        endcase
        return code;
    endfunction

endpackage

@@ hdl/serial_command_line_parser_top.sv @@
// serial command line parser: input register, step logic and result register
// usage:
//   s_valid/s_ready/s_data carry one item per received-byte slot: a byte with
//   its valid bit, plus requests to clear the value and the received flag
//   m_valid/m_ready/m_data return exactly one result item per input item:
//   line end, command pulse, echo letter, current value, sticky received flag
//   and a dropped-byte flag
//   an accepted item waits in the input register and its result is loaded
//   into the result register once that register is free or being emptied
//   throughput: one item per cycle while m_ready is high; the parser state
//   (line position, letter, sign, accumulator, received flag) updates as
//   an item moves into the result register, so the next item always sees
//   the state left by the one before
//   stall: while m_ready is low the result holds, one more item may wait in
//   the input register, and s_ready drops only when both registers are full
//   reset: aresetn low, sampled on aclk, empties both registers and clears
//   all parser state to zero
`timescale 1ns / 1ps

module serial_command_line_parser_top
    import scl_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  scl_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output scl_out_t m_data
);

    // input stage
    logic     in_valid_reg, in_valid_next;
    scl_in_t  in_data_reg;

    // result stage
    logic     out_valid_reg, out_valid_next;
    scl_out_t out_data_reg;

    logic     advance;
    scl_out_t step_result;

    // the held item moves on when the result register is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    scl_core #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_data_reg),
        .result  (step_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // back pressure only when both stages hold an item
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg))
        else $error("s_ready low with a free stage");

    // a dropped byte never ends a line
    a_ovf_term: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.overflow && m_data.line_done))
        else $error("overflow and line_done together");

    // echo goes with a known command and only at a line end
    a_echo_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.echo_valid == (m_data.command != CMD_NONE))
                     && (!m_data.echo_valid || m_data.line_done)))
        else $error("echo does not match command pulse");

    // a line end always leaves the received flag set
    a_done_rcv: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.line_done) |-> m_data.received)
        else $error("line_done without received flag");
`endif

endmodule

@@ hdl/scl_core.sv @@
// parser state registers and the per-item step logic
`timescale 1ns / 1ps

module scl_core
    import scl_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step_en,
    input  scl_in_t  item,
    output scl_out_t result
);

    localparam int POS_W = $clog2(LINE_CAPACITY);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_CAPACITY - 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       letter_reg, letter_next;
    logic             minus_reg, minus_next;
    logic [15:0]      acc_reg, acc_next;
    logic             rcv_reg, rcv_next;

    logic [7:0] b;
    logic       is_term;
    logic [2:0] cmd;

    always_comb begin
        b           = item.rx_byte;
        is_term     = (b == CHAR_LF) || (b == CHAR_CR);
        pos_next    = pos_reg;
        letter_next = letter_reg;
        minus_next  = minus_reg;
        acc_next    = item.clear_value ? 16'd0 : acc_reg;
        rcv_next    = item.clear_received ? 1'b0 : rcv_reg;
        cmd         = CMD_NONE;
        result      = '0;

        if (item.byte_valid) begin
            if (is_term) begin
                result.line_done = 1'b1;
                rcv_next         = 1'b1;
                if (pos_reg != '0) begin
                    if (minus_reg) begin
                        acc_next = 16'd0 - acc_next;
                    end
                    cmd = letter_code(letter_reg);
                end
                pos_next   = '0;
                minus_next = 1'b0;
            end else if (pos_reg >= POS_LAST) begin
                result.overflow = 1'b1;
            end else begin
                if (pos_reg == '0) begin
                    letter_next = b;
                end else if (pos_reg == POS_W'(1) && b == CHAR_MINUS) begin
                    minus_next = 1'b1;
                end else begin
                    // times ten as two shifts, wrapping at 16 bits
                    acc_next = (acc_next << 3) + (acc_next << 1)
                             + {8'd0, b} - {8'd0, CHAR_ZERO};
                end
                pos_next = pos_reg + POS_W'(1);
            end
        end

        result.command    = cmd;
        result.echo_valid = (cmd != CMD_NONE);
        result.echo_byte  = (cmd != CMD_NONE) ? letter_reg : 8'd0;
        result.value      = acc_next;
        result.received   = rcv_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            letter_reg <= '0;
            minus_reg  <= 1'b0;
            acc_reg    <= '0;
            rcv_reg    <= 1'b0;
        end else if (step_en) begin
            pos_reg    <= pos_next;
            letter_reg <= letter_next;
            minus_reg  <= minus_next;
            acc_reg    <= acc_next;
            rcv_reg    <= rcv_next;
        end
    end

endmodule

@@ tb/serial_command_line_parser_top_test.sv @@
// testbench for the serial command line parser: directed and random lines checked against a predictor
`timescale 1ns / 1ps

module serial_command_line_parser_top_test;
    import scl_pkg::*;

    // one item per cycle at best, so the limit mostly covers random gaps and stalls
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 650;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 300;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    scl_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    scl_out_t m_data;

    // items waiting to be offered, and results predicted for accepted items
    scl_in_t  byte_queue[$];
    scl_out_t predicted_results[$];

    int items_total = 0;
    int items_accepted = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int live_items = 0;

    // predictor copy of the parser state
    int          line_pos = 0;
    logic [7:0]  line_letter = '0;
    logic        minus_pending = 1'b0;
    logic [15:0] acc_value = '0;
    logic        line_received = 1'b0;

    serial_command_line_parser_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // advance the parser state by one item and return the result it should produce
    function automatic scl_out_t parse_step(scl_in_t it);
        scl_out_t r;
        r = '0;
        // clears act before the byte
        if (it.clear_value) acc_value = '0;
        if (it.clear_received) line_received = 1'b0;
        if (it.byte_valid) begin
            if (it.rx_byte == CHAR_LF || it.rx_byte == CHAR_CR) begin
                r.line_done = 1'b1;
                line_received = 1'b1;
                // an empty line has no letter and no sign
                if (line_pos != 0) begin
                    if (minus_pending) acc_value = -acc_value;
                    case (line_letter)
                        CHAR_P:  r.command = CMD_P;
                        CHAR_A:  r.command = CMD_A;
                        CHAR_S:  r.command = CMD_S;
                        CHAR_R:  r.command = CMD_R;
                        default: r.command = CMD_NONE;
                    endcase
                    if (r.command != CMD_NONE) begin
                        r.echo_valid = 1'b1;
                        r.echo_byte = line_letter;
                    end
                end
                line_pos = 0;
                minus_pending = 1'b0;
            end else if (line_pos >= LINE_CAPACITY_DEF - 1) begin
                // line full: byte dropped, state untouched
                r.overflow = 1'b1;
            end else begin
                if (line_pos == 0) begin
                    line_letter = it.rx_byte;
                end else if (line_pos == 1 && it.rx_byte == CHAR_MINUS) begin
                    minus_pending = 1'b1;
                end else begin
                    // no digit check, wraps at 16 bits
                    acc_value = acc_value * 16'd10 + {8'd0, it.rx_byte} - {8'd0, CHAR_ZERO};
                end
                line_pos++;
            end
        end
        r.value = acc_value;
        r.received = line_received;
        return r;
    endfunction

    task automatic add_item(logic valid, logic [7:0] b, logic cv, logic cr);
        scl_in_t it;
        it.byte_valid = valid;
        it.rx_byte = b;
        it.clear_value = cv;
        it.clear_received = cr;
        byte_queue.push_back(it);
        items_total++;
        // an item with no byte and no clear does nothing
        if (valid || cv || cr) live_items++;
    endtask

    task automatic add_text(string t);
        for (int i = 0; i < t.len(); i++) add_item(1'b1, t[i], 1'b0, 1'b0);
    endtask

    // a byte with occasional clears and an occasional empty slot ahead of it
    task automatic add_rand_byte(logic [7:0] b);
        if ($urandom_range(0, 99) < 8)
            add_item(1'b0, 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                $urandom_range(0, 2) == 0);
        add_item(1'b1, b, $urandom_range(0, 99) < 4, $urandom_range(0, 99) < 8);
    endtask

    task automatic add_random_line();
        int kind;
        int n;
        logic [7:0] letter;
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            // well-formed line with random content
            case ($urandom_range(0, 4))
                0: letter = CHAR_P;
                1: letter = CHAR_A;
                2: letter = CHAR_S;
                3: letter = CHAR_R;
                default: letter = 8'($urandom_range(0, 255));
            endcase
            if (letter == CHAR_LF || letter == CHAR_CR) letter = CHAR_P;
            add_rand_byte(letter);
            if ($urandom_range(0, 99) < 40) add_rand_byte(CHAR_MINUS);
            // most lines short, some run past the line capacity
            n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 5) : $urandom_range(12, 20);
            for (int i = 0; i < n; i++) add_rand_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
            add_rand_byte($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
        end else if (kind < 90) begin
            // noise, terminators may land anywhere
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) add_rand_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) add_rand_byte(CHAR_LF);
        end else begin
            // broken line: minus late, stray empty slot, line ended early
            add_rand_byte(CHAR_S);
            add_rand_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
            add_rand_byte(CHAR_MINUS);
            add_item(1'b0, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            add_rand_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        end
    endtask

    // stimulus, reset and end of run
    initial begin
        // no byte, both clears
        add_item(1'b0, 8'h00, 1'b1, 1'b1);
        // minus in second place, most negative value
        add_text("p-32768");
        add_item(1'b1, CHAR_LF, 1'b0, 1'b0);
        // most positive value, carriage return
        add_text("a32767");
        add_item(1'b1, CHAR_CR, 1'b0, 1'b0);
        // empty line
        add_item(1'b1, CHAR_CR, 1'b0, 1'b0);
        // minus past second place is taken as a digit
        add_text("s1-");
        add_item(1'b1, CHAR_LF, 1'b0, 1'b0);
        // unknown letter, byte extremes as letter and digit
        add_item(1'b1, 8'hFF, 1'b0, 1'b0);
        add_item(1'b1, 8'h00, 1'b0, 1'b0);
        add_item(1'b1, CHAR_LF, 1'b0, 1'b0);
        // clears together with a byte
        add_item(1'b1, CHAR_R, 1'b0, 1'b0);
        add_item(1'b1, CHAR_ZERO + 8'd5, 1'b1, 1'b1);
        add_item(1'b1, CHAR_LF, 1'b0, 1'b1);

        live_items = 0;
        while (live_items < RANDOM_ITEMS) add_random_line();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_accepted < items_total) @(posedge aclk);
        while (predicted_results.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // sender: offers queued items with random gaps, holds while not accepted
    always @(posedge aclk) begin : drive_items
        int gap;
        int r;
        logic quiet;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
            gap = 0;
            quiet = 1'b0;
        end else begin
            // predict at the accepting edge so state advances in item order
            if (s_valid && s_ready) begin
                predicted_results.push_back(parse_step(s_data));
                items_accepted++;
            end
            if (!(s_valid && !s_ready)) begin
                if (gap > 0) begin
                    gap--;
                    s_valid <= 1'b0;
                end else if (byte_queue.size() > 0) begin
                    s_data <= byte_queue.pop_front();
                    s_valid <= 1'b1;
                    // now and then switch between back-to-back and gappy sending
                    if ($urandom_range(0, 99) < 3) quiet = ~quiet;
                    r = $urandom_range(0, 99);
                    if (quiet || r < 65) gap = 0;
                    else if (r < 92) gap = $urandom_range(1, 3);
                    else gap = $urandom_range(6, 30);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result, stalls at random, and twice holds off long
    // enough that both internal registers fill and s_ready drops
    always @(posedge aclk) begin : take_results
        int stall;
        int hold;
        int r;
        logic quiet;
        logic bad;
        scl_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall = 0;
            hold = 0;
            quiet = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (predicted_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result item: %p", m_data);
                end else begin
                    want = predicted_results.pop_front();
                    bad = (m_data.line_done !== want.line_done)
                        || (m_data.command !== want.command)
                        || (m_data.echo_valid !== want.echo_valid)
                        || (m_data.echo_byte !== want.echo_byte)
                        || (m_data.value !== want.value)
                        || (m_data.received !== want.received)
                        || (m_data.overflow !== want.overflow);
                    if (bad) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("result %0d mismatch", results_seen);
                            $display("  expected done=%b cmd=%0d echo=%b/%h value=%0d rcv=%b ovf=%b",
                                want.line_done, want.command, want.echo_valid,
                                want.echo_byte, want.value, want.received, want.overflow);
                            $display("  actual   done=%b cmd=%0d echo=%b/%h value=%0d rcv=%b ovf=%b",
                                m_data.line_done, m_data.command, m_data.echo_valid,
                                m_data.echo_byte, m_data.value, m_data.received,
                                m_data.overflow);
                        end
                    end
                end
                if (results_seen == 150 || results_seen == 450) hold = LONG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 99) < 2) quiet = ~quiet;
                r = $urandom_range(0, 99);
                if (quiet || r < 70) stall = 0;
                else if (r < 93) stall = $urandom_range(1, 3);
                else stall = $urandom_range(8, 40);
            end
        end
    end

endmodule
